[src/srgbg_pkg.sv]
package srgbg_pkg;

  // default fraction bits of the linear domain
  localparam int unsigned LINEAR_FRAC_BITS_DEF = 16;

  // fixed field widths and table sizes
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned GRAY_W    = 8;
  localparam int unsigned TAB_DEPTH = 256;

  // decode curve split: codes up to this one use the linear segment
  localparam int unsigned LIN_SEG_LAST = 10;
  localparam int unsigned CODE_FULL    = 255;

  // bt.709 weights in units of 1/10000
  localparam int unsigned WT_RED   = 2126;
  localparam int unsigned WT_GREEN = 7152;
  localparam int unsigned WT_BLUE  = 722;

  // q0.32 product, truncated
  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  // fifth power in q0.32
  function automatic logic [63:0] q32_pow5(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = q32_mul(r, r);
    r4 = q32_mul(r2, r2);
    return q32_mul(r4, r);
  endfunction

  // power segment of the decode curve in q0.32, evaluated at elaboration
  function automatic logic [63:0] decode_pow_q32(input int unsigned c);
    logic [63:0] num;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] cand;
    num = 64'(1000 * c) + 64'd14025;
    t   = (num << 32) / 64'd269025;
    s   = q32_mul(t, t);
    r   = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (q32_pow5(cand) <= s) begin
        r = cand;
      end
    end
    return q32_mul(s, r);
  endfunction

  // linear value of a code, rounded half up to q0.f
  function automatic logic [63:0] lin_value(input int unsigned c, input int unsigned f);
    logic [63:0] num;
    logic [63:0] v;
    logic [63:0] res;
    if (c <= LIN_SEG_LAST) begin
      num = 64'(c * 100) << f;
      res = (num + 64'd164730) / 64'd329460;
    end else if (c == CODE_FULL) begin
      res = 64'd1 << f;
    end else begin
      v   = decode_pow_q32(c);
      res = (v + (64'd1 << (31 - f))) >> (32 - f);
    end
    return res;
  endfunction

  // least q0.f value that encodes to at least this code
  function automatic logic [63:0] thr_value(input int unsigned c, input int unsigned f);
    logic [63:0] num;
    logic [63:0] v;
    logic [63:0] res;
    if (c <= LIN_SEG_LAST) begin
      num = 64'(c * 100) << f;
      res = (num + 64'd329459) / 64'd329460;
    end else if (c == CODE_FULL) begin
      res = 64'd1 << f;
    end else begin
      v   = decode_pow_q32(c);
      res = (v + (64'd1 << (32 - f)) - 64'd1) >> (32 - f);
    end
    return res;
  endfunction

  // weight in q0.f, rounded half up
  function automatic logic [63:0] weight(input int unsigned w, input int unsigned f);
    return ((64'(w) << f) + 64'd5000) / 64'd10000;
  endfunction

endpackage

[src/srgb_to_gray_luminance.sv]
// pipeline: lookup, multiply, sum and 8 search steps, one register stage each
// throughput: one item per cycle while out_stall is low; every stage holds one item and the search uses one
// threshold compare per stage
// stall: a stage advances when empty or when its successor takes its item
// reset: synchronous active-low reset clears all valid bits; tables are constants, no fill
module srgb_to_gray_luminance #(
  parameter int unsigned LINEAR_FRAC_BITS = srgbg_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srgbg_pkg::CHAN_W-1:0]  in_red,
  input  logic [srgbg_pkg::CHAN_W-1:0]  in_green,
  input  logic [srgbg_pkg::CHAN_W-1:0]  in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srgbg_pkg::GRAY_W-1:0]  out_gray
);

  localparam int unsigned F  = LINEAR_FRAC_BITS;
  localparam int unsigned LW = F + 1;
  localparam int unsigned WW = F;
  localparam int unsigned PW = WW + LW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned YW = F + 1;

  localparam logic [63:0] W_RED_64   = srgbg_pkg::weight(srgbg_pkg::WT_RED, F);
  localparam logic [63:0] W_GREEN_64 = srgbg_pkg::weight(srgbg_pkg::WT_GREEN, F);
  localparam logic [63:0] W_BLUE_64  = srgbg_pkg::weight(srgbg_pkg::WT_BLUE, F);
  localparam logic [WW-1:0] W_RED   = WW'(W_RED_64);
  localparam logic [WW-1:0] W_GREEN = WW'(W_GREEN_64);
  localparam logic [WW-1:0] W_BLUE  = WW'(W_BLUE_64);

  // linearising table of the decode curve
  logic [LW-1:0] lin_rom [srgbg_pkg::TAB_DEPTH];

  for (genvar c = 0; c < srgbg_pkg::TAB_DEPTH; c++) begin : g_lin
    localparam logic [63:0] LV = srgbg_pkg::lin_value(c, F);
    assign lin_rom[c] = LW'(LV);
  end

  logic          v1_r, v2_r, v3_r;
  logic          rdy1, rdy2, rdy3;
  logic          srch_ready;
  logic [LW-1:0] lr_r, lg_r, lb_r;
  logic [PW-1:0] pr_r, pg_r, pb_r;
  logic [PW-1:0] pr_nxt, pg_nxt, pb_nxt;
  logic [SW-1:0] sum;
  logic [YW-1:0] y3_r;
  logic [YW-1:0] y3_nxt;

  // stage ready chain
  assign rdy3     = !v3_r || srch_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // stage 1: linearise each channel
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      lr_r <= lin_rom[in_red];
      lg_r <= lin_rom[in_green];
      lb_r <= lin_rom[in_blue];
    end
  end

  // stage 2: weight each channel
  assign pr_nxt = PW'(W_RED) * PW'(lr_r);
  assign pg_nxt = PW'(W_GREEN) * PW'(lg_r);
  assign pb_nxt = PW'(W_BLUE) * PW'(lb_r);

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      pr_r <= pr_nxt;
      pg_r <= pg_nxt;
      pb_r <= pb_nxt;
    end
  end

  // stage 3: luminance, truncated back to q0.f
  assign sum    = SW'(pr_r) + SW'(pg_r) + SW'(pb_r);
  assign y3_nxt = YW'(sum >> F);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      y3_r <= y3_nxt;
    end
  end

  // gamma encode as a search over the threshold table
  srgbg_search #(
    .FRAC_BITS (F)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v3_r),
    .up_y      (y3_r),
    .up_ready  (srch_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_gray  (out_gray)
  );

  // input is refused only while the first stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input refused with empty first stage");

  // a held luminance item stays put until the search takes it
  a_lum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !srch_ready |=> v3_r && $stable(y3_r))
    else $error("luminance item lost under stall");

  // weighted sum never exceeds one plus rounding
  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> y3_r <= YW'((64'd1 << F) + 64'd1))
    else $error("luminance out of range");

endmodule

[src/srgbg_search.sv]
module srgbg_search #(
  parameter int unsigned FRAC_BITS = srgbg_pkg::LINEAR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  input  logic [FRAC_BITS:0]            up_y,
  output logic                          up_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srgbg_pkg::GRAY_W-1:0]  out_gray
);

  localparam int unsigned YW    = FRAC_BITS + 1;
  localparam int unsigned GW    = srgbg_pkg::GRAY_W;
  localparam int unsigned STEPS = srgbg_pkg::GRAY_W;

  // threshold table, entry k is the least luminance giving gray k
  logic [YW-1:0] thr_rom [srgbg_pkg::TAB_DEPTH];

  for (genvar c = 0; c < srgbg_pkg::TAB_DEPTH; c++) begin : g_thr
    localparam logic [63:0] TV = srgbg_pkg::thr_value(c, FRAC_BITS);
    assign thr_rom[c] = YW'(TV);
  end

  logic          v_r [STEPS];
  logic [YW-1:0] y_r [STEPS];
  logic [GW-1:0] g_r [STEPS];
  logic          rdy [STEPS+1];

  assign rdy[STEPS] = !out_stall;

  // one bit of the binary search per stage, msb first
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic          vp;
    logic [YW-1:0] yp;
    logic [GW-1:0] gp;
    logic [GW-1:0] cand;
    logic [GW-1:0] g_nxt;

    if (i == 0) begin : g_first
      assign vp = up_valid;
      assign yp = up_y;
      assign gp = '0;
    end else begin : g_rest
      assign vp = v_r[i-1];
      assign yp = y_r[i-1];
      assign gp = g_r[i-1];
    end

    // keep the candidate bit when its threshold is reached
    assign cand  = gp | GW'(1 << (STEPS - 1 - i));
    assign g_nxt = (thr_rom[cand] <= yp) ? cand : gp;

    // stage moves when empty or when the next one takes its item
    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= vp;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && vp) begin
        y_r[i] <= yp;
        g_r[i] <= g_nxt;
      end
    end
  end

  assign up_ready  = rdy[0];
  assign out_valid = v_r[STEPS-1];
  assign out_gray  = g_r[STEPS-1];

  // finished gray lies at the last threshold not above the luminance
  a_gray_low: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STEPS-1] |-> (g_r[STEPS-1] == '0) || (thr_rom[g_r[STEPS-1]] <= y_r[STEPS-1]))
    else $error("gray above its threshold");

  a_gray_high: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STEPS-1] |-> (g_r[STEPS-1] == '1) ||
                     (thr_rom[GW'(g_r[STEPS-1] + 1'b1)] > y_r[STEPS-1]))
    else $error("gray below next threshold");

  // a full first stage that cannot move keeps its item
  a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !rdy[1] |=> v_r[0] && $stable(y_r[0]) && $stable(g_r[0]))
    else $error("search stage lost its item");

endmodule
